### sv/scvp_pkg.sv
// Package: shared types, constants and the context hash multiplier for the value predictor.
`timescale 1ns / 1ps
`default_nettype none
package scvp_pkg;

  localparam int unsigned ContextEntries = 1024;
  localparam int unsigned HistoryDepth   = 4;
  localparam int unsigned HistoryEntries = 256;

  localparam logic [31:0] HashMul = 32'd2654435761;

  localparam int unsigned RegThreshold = 0;
  localparam int unsigned RegConfMax   = 1;

  typedef enum logic [2:0] {
    ST_PREDICTED   = 3'd0,
    ST_NO_HISTORY  = 3'd1,
    ST_NO_STRIDE   = 3'd2,
    ST_LOW_CONF    = 3'd3,
    ST_FIRST_SEEN  = 3'd4,
    ST_TRAINED     = 3'd5,
    ST_PEND_RIGHT  = 3'd6,
    ST_PEND_WRONG  = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_HASH,
    S_CTX,
    S_EXEC,
    S_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic clear_step;
    logic take_req;
    logic read_hist;
    logic hash_step;
    logic read_ctx;
    logic exec;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_done;
    logic hash_done;
  } stat_t;

endpackage
`default_nettype wire

### sv/scvp_ram.sv
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module scvp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### sv/scvp_ctrl.sv
// Controller: sequences read, hash, context read, execute and output per request.
`timescale 1ns / 1ps
`default_nettype none
module scvp_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  input  wire scvp_pkg::stat_t stat_i,
  output scvp_pkg::cmd_t      cmd_o
);
  import scvp_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLEAR;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (stat_i.clear_done) state_d = S_IDLE;
      S_IDLE: if (in_valid_i) state_d = S_READ;
      S_READ: state_d = S_HASH;
      S_HASH: if (stat_i.hash_done) state_d = S_CTX;
      S_CTX:  state_d = S_EXEC;
      S_EXEC: state_d = S_OUT;
      S_OUT:  if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_CLEAR: cmd_o.clear_step = 1'b1;
      S_IDLE: begin
        in_stall_o       = 1'b0;
        cmd_o.take_req   = in_valid_i;
      end
      S_READ: cmd_o.read_hist = 1'b1;
      S_HASH: cmd_o.hash_step = 1'b1;
      S_CTX:  cmd_o.read_ctx  = 1'b1;
      S_EXEC: cmd_o.exec      = 1'b1;
      S_OUT:  out_valid_o     = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

### sv/scvp_dp.sv
// Datapath: history and context tables, hash unit, training and result registers.
`timescale 1ns / 1ps
`default_nettype none
module scvp_dp #(
  parameter int unsigned ContextEntries = scvp_pkg::ContextEntries,
  parameter int unsigned HistoryDepth   = scvp_pkg::HistoryDepth,
  parameter int unsigned HistoryEntries = scvp_pkg::HistoryEntries
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire scvp_pkg::cmd_t  cmd_i,
  output scvp_pkg::stat_t      stat_o,
  input  wire logic            cfg_we_i,
  input  wire logic            cfg_index_i,
  input  wire logic [3:0]      cfg_data_i,
  input  wire logic            kind_i,
  input  wire logic [63:0]     pc_i,
  input  wire logic [63:0]     actual_value_i,
  output logic                 pred_valid_o,
  output logic [63:0]          pred_value_o,
  output logic [2:0]           status_o
);
  import scvp_pkg::*;

  localparam int unsigned HW = (HistoryEntries > 1) ? $clog2(HistoryEntries) : 1;
  localparam int unsigned CW = (ContextEntries > 1) ? $clog2(ContextEntries) : 1;
  localparam int unsigned DW = (HistoryDepth > 1) ? $clog2(HistoryDepth) : 1;
  localparam int unsigned SW = 64 * HistoryDepth;
  // entry: tag, last, strides, wp, stride_valid, pending_flag, pending_value
  localparam int unsigned EW = 64 + 64 + SW + DW + 1 + 1 + 64;

  typedef struct packed {
    logic [63:0]   tag;
    logic [63:0]   last;
    logic [SW-1:0] strides;
    logic [DW-1:0] wp;
    logic          sval;
    logic          pend;
    logic [63:0]   pval;
  } hent_t;

  logic [3:0] thr_q, cmax_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= 4'd2;
      cmax_q <= 4'd3;
    end else if (cfg_we_i) begin
      if (cfg_index_i == RegThreshold[0]) thr_q  <= cfg_data_i;
      else                                cmax_q <= cfg_data_i;
    end
  end

  logic        kind_q;
  logic [63:0] pc_q, act_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_req) begin
      kind_q <= kind_i;
      pc_q   <= pc_i;
      act_q  <= actual_value_i;
    end
  end
  wire [HW-1:0] slot = pc_q[HW-1:0];

  // history valid bits in flops, payload in RAM
  logic [HistoryEntries-1:0] hvalid_q;

  logic          h_we;
  hent_t         h_wd, h_rd;
  logic [EW-1:0] h_rd_raw;
  scvp_ram #(.Width(EW), .Depth(HistoryEntries)) u_hist (
    .clk_i, .we_i(h_we), .waddr_i(slot), .wdata_i(h_wd),
    .raddr_i(pc_i[HW-1:0]), .rdata_o(h_rd_raw)
  );
  assign h_rd = hent_t'(h_rd_raw);

  hent_t ent_q;
  logic  hit_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.read_hist) begin
      ent_q <= h_rd;
      hit_q <= hvalid_q[slot] && (h_rd.tag == pc_q);
    end
  end

  // hash: one stride per cycle, newest first; multiply registered before fold
  logic [63:0] h_q;
  logic [DW:0] hcnt_q;
  logic [63:0] prod_q;
  logic        pv_q;
  logic [DW-1:0] kidx;
  logic [63:0] sel;
  logic [63:0] hx;
  logic [63:0] hrot;
  always_comb begin
    // the multiply runs one stride ahead of the fold
    kidx = DW'((32'(ent_q.wp) + HistoryDepth - 1 - 32'(hcnt_q) - 32'(pv_q)) % HistoryDepth);
    sel  = ent_q.strides[64*kidx +: 64];
    hx   = h_q ^ prod_q;
    hrot = {hx[58:0], hx[63:59]};
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.read_hist) begin
      h_q    <= pc_q ^ {32'd0, pc_q[63:32]};
      hcnt_q <= '0;
      pv_q   <= 1'b0;
    end else if (cmd_i.hash_step) begin
      // product of the low 32 bits plus high-part cross term, taken modulo 2^64
      prod_q <= 64'(sel[31:0] * HashMul) + {sel[63:32] * HashMul, 32'd0};
      pv_q   <= 1'b1;
      if (pv_q) begin
        h_q    <= hrot;
        hcnt_q <= hcnt_q + 1'b1;
        pv_q   <= (hcnt_q + 1'b1 < (DW+1)'(HistoryDepth)) ? 1'b1 : 1'b0;
      end
    end
  end
  // done on the last fold; the index comes from the rotated value
  assign stat_o.hash_done = pv_q && (hcnt_q == (DW+1)'(HistoryDepth - 1));
  wire [CW-1:0] cidx_d = CW'(hrot[31:0] % ContextEntries);

  logic [CW-1:0] cidx_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.hash_step && stat_o.hash_done) cidx_q <= cidx_d;
  end

  // clearing pass over the context table after reset
  logic [CW-1:0] clr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)               clr_q <= '0;
    else if (cmd_i.clear_step) clr_q <= clr_q + 1'b1;
  end
  assign stat_o.clear_done = (clr_q == CW'(ContextEntries - 1));

  // context entry: valid, stride, confidence
  logic          c_we;
  logic [68:0]   c_wd, c_rd;
  wire  [CW-1:0] c_waddr = cmd_i.clear_step ? clr_q : cidx_q;
  scvp_ram #(.Width(69), .Depth(ContextEntries)) u_ctx (
    .clk_i, .we_i(c_we), .waddr_i(c_waddr), .wdata_i(c_wd),
    .raddr_i(cidx_q), .rdata_o(c_rd)
  );
  wire        cval  = c_rd[68];
  wire [63:0] cstr  = c_rd[67:4];
  wire [3:0]  cconf = c_rd[3:0];

  wire [63:0] stride = act_q - ent_q.last;
  wire [63:0] psum   = ent_q.last + cstr;

  logic [2:0]  st;
  logic        pvalid;
  logic        ctrain;
  logic [3:0]  nconf;
  logic [63:0] nstr;
  always_comb begin
    h_wd   = ent_q;
    h_we   = 1'b0;
    st     = ST_NO_HISTORY;
    pvalid = 1'b0;
    ctrain = 1'b0;
    nconf  = cconf;
    nstr   = cstr;
    if (!kind_q) begin
      if (!hit_q) st = ST_NO_HISTORY;
      else if (!ent_q.sval) st = ST_NO_STRIDE;
      else if (!cval || cconf < thr_q) st = ST_LOW_CONF;
      else begin
        st         = ST_PREDICTED;
        pvalid     = 1'b1;
        h_we       = 1'b1;
        h_wd.pend  = 1'b1;
        h_wd.pval  = psum;
      end
    end else if (!hit_q) begin
      st           = ST_FIRST_SEEN;
      h_we         = 1'b1;
      h_wd.tag     = pc_q;
      h_wd.strides = '0;
      h_wd.wp      = '0;
      h_wd.sval    = 1'b0;
      h_wd.pend    = 1'b0;
      h_wd.last    = act_q;
    end else begin
      st = ST_TRAINED;
      if (ent_q.pend) st = (act_q == ent_q.pval) ? ST_PEND_RIGHT : ST_PEND_WRONG;
      h_we      = 1'b1;
      h_wd.pend = 1'b0;
      if (ent_q.sval) begin
        ctrain = 1'b1;
        if (!cval) begin
          nstr  = stride;
          nconf = 4'd1;
        end else if (stride == cstr) begin
          if (cconf < cmax_q) nconf = cconf + 4'd1;
        end else if (cconf <= 4'd1) begin
          nstr  = stride;
          nconf = 4'd1;
        end else nconf = cconf - 4'd1;
      end
      h_wd.strides[64*ent_q.wp +: 64] = stride;
      h_wd.wp   = DW'((32'(ent_q.wp) + 1) % HistoryDepth);
      h_wd.sval = 1'b1;
      h_wd.last = act_q;
    end
    h_we = h_we && cmd_i.exec;
    c_we = (ctrain && cmd_i.exec) || cmd_i.clear_step;
    c_wd = cmd_i.clear_step ? 69'd0 : {1'b1, nstr, nconf};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hvalid_q <= '0;
    end else begin
      if (h_we) hvalid_q[slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      pred_valid_o <= pvalid;
      pred_value_o <= pvalid ? psum : 64'd0;
      status_o     <= st;
    end
  end
endmodule
`default_nettype wire

### sv/stride_context_value_predictor_unit.sv
// Top level: differential-context load value predictor.
//  channel | valid      | stall      | payload
//  in      | in_valid_i | in_stall_o | kind_i, pc_i, actual_value_i
//  out     | out_valid_o| out_stall_i| pred_valid_o, pred_value_o, status_o
//  cfg     | cfg_we_i   | -          | cfg_index_i, cfg_data_i
// One request at a time: accept, history read, serial hash over the stride
// ring (strides multiplied and folded in turn, the multiply one stride ahead
// of the fold), context read, execute, output. The serial hash is the
// longest step. After reset a clearing pass zeroes the context table with
// input stalled; history valid bits clear at reset.
// A stalled result holds; input is stalled until the result is taken.
`timescale 1ns / 1ps
`default_nettype none
module stride_context_value_predictor_unit #(
  parameter int unsigned ContextEntries = scvp_pkg::ContextEntries,
  parameter int unsigned HistoryDepth   = scvp_pkg::HistoryDepth,
  parameter int unsigned HistoryEntries = scvp_pkg::HistoryEntries
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        kind_i,
  input  wire logic [63:0] pc_i,
  input  wire logic [63:0] actual_value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             pred_valid_o,
  output logic [63:0]      pred_value_o,
  output logic [2:0]       status_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [3:0]  cfg_data_i
);
  import scvp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  scvp_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  scvp_dp #(
    .ContextEntries(ContextEntries), .HistoryDepth(HistoryDepth),
    .HistoryEntries(HistoryEntries)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .kind_i, .pc_i, .actual_value_i,
    .pred_valid_o, .pred_value_o, .status_o
  );
endmodule
`default_nettype wire
